// ===== rtl/linear_probe_hash_table_macros.svh =====
// Assertion macros for the linear probe hash table
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define LPHT_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define LPHT_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define LPHT_ASSERT_IMP(label, clk, rst_n, a, c)
`define LPHT_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== rtl/lpht_pkg.sv =====
// Package with commands, status codes and defaults of the hash table
package lpht_pkg;
    localparam int MAX_SLOTS_DEF = 1024;
    localparam int KEY_CHARS_DEF = 8;
    localparam int CAP_W = 11;
    localparam int SLOT_OUT_W = 10;
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;
    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_ERASE = 3'd1;
    localparam logic [2:0] CMD_SEARCH = 3'd2;
    localparam logic [2:0] CMD_FIRST = 3'd3;
    localparam logic [2:0] CMD_NEXT = 3'd4;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_DUP = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;
endpackage

// ===== rtl/lpht_mod.sv =====
// Serial reduction of the 64-bit hash modulo the table capacity
module lpht_mod #(
    parameter int IW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [63:0]   i_num,
    input  logic [IW-1:0] i_den,
    output logic          o_done,
    output logic [IW-1:0] o_rem
);
    logic [IW:0]   r_rem;
    logic [63:0]   r_num;
    logic [6:0]    r_cnt;
    logic          r_busy;
    logic [IW+1:0] w_sh;
    logic [IW+1:0] w_sub;

    assign w_sh = {r_rem, r_num[63]};
    assign w_sub = w_sh - {2'b00, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                o_done <= 1'b0;
                r_cnt <= 7'd0;
                r_num <= i_num;
                r_rem <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[62:0], 1'b0};
                if (!w_sub[IW+1]) r_rem <= w_sub[IW:0];
                else r_rem <= w_sh[IW:0];
                r_cnt <= r_cnt + 7'd1;
                o_done <= (r_cnt == 7'd63);
                if (r_cnt == 7'd63) r_busy <= 1'b0;
            end else begin
                o_done <= 1'b0;
            end
        end
    end
    assign o_rem = r_rem[IW-1:0];
endmodule

// ===== rtl/linear_probe_hash_table.sv =====
// Top level of the linear probe hash table
// Channels: s_axis carries one command item per handshake,
//   tdata = {value, key, command} from the highest bit down, 136 bits.
//   m_axis returns one result item per command,
//   tdata = {entry_count, slot_index, found_value, found_key, status}, 152 bits.
// Configuration: i_cfg_we with i_cfg_data writes the table capacity; the write
//   takes effect only while the table holds no live entry and clears it.
// Throughput: one command at a time. Insert, erase and search run the hash and
//   the bit-serial modulo, then read and check each probed slot; first and next
//   read and check each scanned slot. The probe loop is set by the single read
//   port of the slot memory, which has a registered read.
// After reset the table is empty; used and live bits clear over a sweep of
//   all MAX_SLOTS slots during which no item is accepted.
// When the receiver stalls the result holds in the output register and the
//   next item waits until it is taken.
`include "linear_probe_hash_table_macros.svh"
module linear_probe_hash_table #(
    parameter int MAX_SLOTS = lpht_pkg::MAX_SLOTS_DEF,
    parameter int KEY_CHARS = lpht_pkg::KEY_CHARS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,   // command[2:0], key[66:3], value[130:67]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [151:0] m_axis_tdata,   // status, found_key, found_value, slot, count
    input  logic         i_cfg_we,
    input  logic [10:0]  i_cfg_data
);
    localparam int AW = $clog2(MAX_SLOTS);
    localparam int CW = lpht_pkg::CAP_W;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_HASH, S_MOD, S_RD, S_CHK, S_WR, S_OUT
    } t_state;

    t_state r_state;
    logic [63:0] mem_key [MAX_SLOTS];
    logic [63:0] mem_val [MAX_SLOTS];
    logic [1:0]  mem_flg [MAX_SLOTS];

    logic [AW-1:0] r_clr;
    logic [2:0]    r_cmd;
    logic [63:0]   r_key, r_val, r_h;
    logic [3:0]    r_hi;
    logic          r_hend;
    logic [CW-1:0] r_cap, r_count, r_n;
    logic [CW-1:0] r_pos;
    logic [CW-1:0] r_cur;
    logic          r_cur_v;
    logic [63:0]   r_rk, r_rv;
    logic [1:0]    r_rf;
    logic          r_have_free;
    logic [CW-1:0] r_free;
    logic          r_mstart;
    logic          w_mdone;
    logic [CW-1:0] w_mrem;
    logic          r_ov;
    logic [1:0]    r_ost;
    logic [63:0]   r_ok, r_oval;
    logic [9:0]    r_oslot;
    logic [CW-1:0] r_ocnt;

    logic [63:0] w_clean;
    logic [7:0]  w_b;
    logic [CW-1:0] w_posn;
    logic [CW:0]   w_cfgv;

    always_comb begin
        logic stop;
        stop = 1'b0;
        w_clean = '0;
        for (int i = 0; i < 8; i++) begin
            if (i >= KEY_CHARS || s_axis_tdata[3+8*i +: 8] == 8'd0) stop = 1'b1;
            if (!stop) w_clean[8*i +: 8] = s_axis_tdata[3+8*i +: 8];
        end
    end

    assign w_b = r_key[8*r_hi[2:0] +: 8];
    assign w_posn = (r_pos + 1'b1 < r_cap) ? r_pos + 1'b1 : '0;
    assign w_cfgv = (i_cfg_data == 11'd0) ? 12'd1 :
                    ({1'b0, i_cfg_data} > 12'(MAX_SLOTS)) ? 12'(MAX_SLOTS) :
                    {1'b0, i_cfg_data};
    assign s_axis_tready = (r_state == S_IDLE) && !r_ov && !i_cfg_we;

    lpht_mod #(.IW(CW)) u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_mstart), .i_num(r_h),
        .i_den(r_cap), .o_done(w_mdone), .o_rem(w_mrem)
    );

    always_ff @(posedge i_clk) begin
        r_rk <= mem_key[r_pos[AW-1:0]];
        r_rv <= mem_val[r_pos[AW-1:0]];
        r_rf <= mem_flg[r_pos[AW-1:0]];
        if (r_state == S_CLR) mem_flg[r_clr] <= 2'b00;
        else if (r_state == S_WR) begin
            if (r_cmd == lpht_pkg::CMD_INSERT) begin
                mem_key[r_free[AW-1:0]] <= r_key;
                mem_val[r_free[AW-1:0]] <= r_val;
                mem_flg[r_free[AW-1:0]] <= 2'b11;
            end else mem_flg[r_pos[AW-1:0]] <= 2'b01;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr <= '0;
            r_cap <= (CW'(MAX_SLOTS) < lpht_pkg::CAP_RESET) ? CW'(MAX_SLOTS)
                     : lpht_pkg::CAP_RESET;
            r_count <= '0;
            r_cur_v <= 1'b0;
            r_cur <= '0;
            r_ov <= 1'b0;
            r_mstart <= 1'b0;
            r_pos <= '0;
        end else begin
            if (r_ov && m_axis_tready) r_ov <= 1'b0;
            if (i_cfg_we && r_count == '0 && (r_state == S_IDLE || r_state == S_CLR)) begin
                r_cap <= w_cfgv[CW-1:0];
                r_cur_v <= 1'b0;
                r_clr <= '0;
                r_state <= S_CLR;
            end else begin
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(MAX_SLOTS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_cmd <= s_axis_tdata[2:0];
                    r_key <= w_clean;
                    r_val <= s_axis_tdata[130:67];
                    r_h <= '0; r_hi <= '0; r_hend <= 1'b0;
                    r_have_free <= 1'b0;
                    r_n <= '0;
                    r_ost <= lpht_pkg::ST_MISS; r_ok <= '0; r_oval <= '0;
                    r_oslot <= '0;
                    if (s_axis_tdata[2:0] <= lpht_pkg::CMD_SEARCH) r_state <= S_HASH;
                    else if (s_axis_tdata[2:0] == lpht_pkg::CMD_FIRST) begin
                        r_pos <= '0; r_state <= S_RD;
                    end else if (s_axis_tdata[2:0] == lpht_pkg::CMD_NEXT) begin
                        r_pos <= r_cur_v ? r_cur + 1'b1 : '0; r_state <= S_RD;
                    end else r_state <= S_OUT;
                end
                S_HASH: begin
                    if (r_hi == 4'd8 || w_b == 8'd0 || r_hend) begin
                        r_mstart <= 1'b1;
                        r_state <= S_MOD;
                    end else begin
                        r_h <= r_h + {r_h[58:0], 5'b0} + 64'((w_b >= 8'h41 &&
                               w_b <= 8'h5A) ? w_b + 8'h20 : w_b);
                        r_hi <= r_hi + 1'b1;
                    end
                end
                S_MOD: begin
                    r_mstart <= 1'b0;
                    if (w_mdone) begin
                        r_pos <= w_mrem;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    if (r_cmd >= lpht_pkg::CMD_FIRST && r_pos >= r_cap) r_state <= S_OUT;
                    else if (r_cmd <= lpht_pkg::CMD_SEARCH && r_n == r_cap) begin
                        if (r_cmd == lpht_pkg::CMD_INSERT) begin
                            if (r_have_free) begin
                                r_ost <= lpht_pkg::ST_OK; r_state <= S_WR;
                            end else r_ost <= lpht_pkg::ST_FULL;
                            if (!r_have_free) r_state <= S_OUT;
                        end else begin
                            if (r_cmd == lpht_pkg::CMD_SEARCH) begin
                                r_oslot <= r_pos[9:0]; r_cur <= r_pos; r_cur_v <= 1'b1;
                            end
                            r_state <= S_OUT;
                        end
                    end else r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_cmd >= lpht_pkg::CMD_FIRST) begin
                        if (r_rf == 2'b11) begin
                            r_ost <= lpht_pkg::ST_OK; r_ok <= r_rk; r_oval <= r_rv;
                            r_oslot <= r_pos[9:0]; r_cur <= r_pos; r_cur_v <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_pos <= r_pos + 1'b1; r_state <= S_RD;
                        end
                    end else if (!r_rf[0]) begin
                        unique case (r_cmd)
                            lpht_pkg::CMD_INSERT: begin
                                if (!r_have_free) r_free <= r_pos;
                                r_ost <= lpht_pkg::ST_OK; r_state <= S_WR;
                            end
                            lpht_pkg::CMD_SEARCH: begin
                                r_oslot <= r_pos[9:0]; r_cur <= r_pos; r_cur_v <= 1'b1;
                                r_state <= S_OUT;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end else if (r_rf[1] && r_rk == r_key) begin
                        r_oslot <= r_pos[9:0];
                        unique case (r_cmd)
                            lpht_pkg::CMD_INSERT: begin
                                r_ost <= lpht_pkg::ST_DUP; r_state <= S_OUT;
                            end
                            lpht_pkg::CMD_ERASE: begin
                                r_ost <= lpht_pkg::ST_OK; r_state <= S_WR;
                            end
                            default: begin
                                r_ost <= lpht_pkg::ST_OK; r_ok <= r_rk; r_oval <= r_rv;
                                r_cur <= r_pos; r_cur_v <= 1'b1; r_state <= S_OUT;
                            end
                        endcase
                    end else begin
                        if (!r_rf[1] && !r_have_free) begin
                            r_have_free <= 1'b1; r_free <= r_pos;
                        end
                        r_pos <= w_posn; r_n <= r_n + 1'b1; r_state <= S_RD;
                    end
                end
                S_WR: begin
                    if (r_cmd == lpht_pkg::CMD_INSERT) begin
                        r_count <= r_count + 1'b1; r_oslot <= r_free[9:0];
                    end else if (r_count != '0) r_count <= r_count - 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_ocnt <= r_count;
                    r_ov <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            end
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = {1'b0, r_ocnt, r_oslot, r_oval, r_ok, r_ost};

    `LPHT_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, s_axis_tready, !r_ov)
    `LPHT_ASSERT_NXT(a_out_once, i_clk, i_rst_n, r_state == S_OUT, r_ov)
    `LPHT_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= r_cap)
endmodule

// ===== sim/tb_linear_probe_hash_table.sv =====
// Self-checking testbench for the linear probe hash table
`timescale 1ns / 1ps

module tb_linear_probe_hash_table;

    typedef struct packed {
        logic [63:0] val;
        logic [63:0] key;
        logic [2:0]  cmd;
    } t_cmd_item;

    typedef struct packed {
        logic [10:0] count;
        logic [9:0]  slot;
        logic [63:0] fval;
        logic [63:0] fkey;
        logic [1:0]  status;
    } t_result;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;   // command[2:0], key[66:3], value[130:67], zero pad
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [151:0] m_axis_tdata;   // status[1:0], found_key[65:2], found_value[129:66],
                                  // slot_index[139:130], entry_count[150:140], zero pad
    logic         i_cfg_we;
    logic [10:0]  i_cfg_data;

    linear_probe_hash_table uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data)
    );

    // shadow table
    logic [63:0] tbl_key [lpht_pkg::MAX_SLOTS_DEF];
    logic [63:0] tbl_val [lpht_pkg::MAX_SLOTS_DEF];
    logic        tbl_used [lpht_pkg::MAX_SLOTS_DEF];
    logic        tbl_live [lpht_pkg::MAX_SLOTS_DEF];
    logic [10:0] live_cnt;
    int          cur_pos;
    logic        cur_ok;
    int          cap;

    t_cmd_item   pending_cmds[$];
    t_result     expected_results[$];
    logic [63:0] key_pool[$];
    int          fails = 0;
    int          results_seen;
    int          stall_left;
    logic        stall_done;
    logic        quiet;

    function automatic logic [63:0] clean_key(logic [63:0] k);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (k[8*i +: 8] == 8'd0) break;
            r[8*i +: 8] = k[8*i +: 8];
        end
        return r;
    endfunction

    function automatic int home_of(logic [63:0] k);
        logic [63:0] h;
        logic [7:0]  b;
        h = '0;
        for (int i = 0; i < 8; i++) begin
            b = k[8*i +: 8];
            if (b == 8'd0) break;
            if (b >= "A" && b <= "Z") b = b + 8'h20;
            h = h * 64'd33 + {56'd0, b};
        end
        return int'(h % 64'(cap));
    endfunction

    function automatic void table_clear();
        for (int i = 0; i < lpht_pkg::MAX_SLOTS_DEF; i++) begin
            tbl_used[i] = 1'b0;
            tbl_live[i] = 1'b0;
        end
        cur_pos = 0;
        cur_ok = 1'b0;
    endfunction

    function automatic void capacity_write(logic [10:0] v);
        if (live_cnt != 0) return;
        cap = (v < 1) ? 1 : (v > lpht_pkg::MAX_SLOTS_DEF) ? lpht_pkg::MAX_SLOTS_DEF : int'(v);
        table_clear();
    endfunction

    function automatic t_result table_apply(t_cmd_item it);
        t_result r;
        logic [63:0] k;
        int pos, n, hit, free_pos, i;
        logic got, have_free;
        r = '{status: lpht_pkg::ST_MISS, fkey: '0, fval: '0, slot: '0, count: '0};
        k = clean_key(it.key);
        got = 1'b0;
        have_free = 1'b0;
        hit = 0;
        free_pos = 0;
        if (it.cmd == lpht_pkg::CMD_INSERT || it.cmd == lpht_pkg::CMD_ERASE ||
            it.cmd == lpht_pkg::CMD_SEARCH) begin
            pos = home_of(k);
            for (n = 0; n < cap; n++) begin
                if (!tbl_used[pos]) break;
                if (tbl_live[pos]) begin
                    if (tbl_key[pos] == k) begin
                        got = 1'b1;
                        hit = pos;
                        break;
                    end
                end else if (!have_free) begin
                    have_free = 1'b1;
                    free_pos = pos;
                end
                pos = (pos + 1 < cap) ? pos + 1 : 0;
            end
            if (it.cmd == lpht_pkg::CMD_INSERT) begin
                if (got) begin
                    r.status = lpht_pkg::ST_DUP;
                    r.slot = hit[9:0];
                end else begin
                    if (!have_free && n < cap) begin
                        have_free = 1'b1;
                        free_pos = pos;
                    end
                    if (have_free) begin
                        tbl_key[free_pos] = k;
                        tbl_val[free_pos] = it.val;
                        tbl_used[free_pos] = 1'b1;
                        tbl_live[free_pos] = 1'b1;
                        live_cnt++;
                        r.status = lpht_pkg::ST_OK;
                        r.slot = free_pos[9:0];
                    end else begin
                        r.status = lpht_pkg::ST_FULL;
                    end
                end
            end else if (it.cmd == lpht_pkg::CMD_ERASE) begin
                if (got) begin
                    tbl_live[hit] = 1'b0;
                    if (live_cnt > 0) live_cnt--;
                    r.status = lpht_pkg::ST_OK;
                    r.slot = hit[9:0];
                end
            end else begin
                if (got) begin
                    r.status = lpht_pkg::ST_OK;
                    r.fkey = tbl_key[hit];
                    r.fval = tbl_val[hit];
                    r.slot = hit[9:0];
                    cur_pos = hit;
                end else begin
                    r.slot = pos[9:0];
                    cur_pos = pos;
                end
                cur_ok = 1'b1;
            end
        end else if (it.cmd == lpht_pkg::CMD_FIRST || it.cmd == lpht_pkg::CMD_NEXT) begin
            i = (it.cmd == lpht_pkg::CMD_NEXT && cur_ok) ? cur_pos + 1 : 0;
            for (; i < cap; i++) begin
                if (tbl_used[i] && tbl_live[i]) begin
                    cur_pos = i;
                    cur_ok = 1'b1;
                    r.status = lpht_pkg::ST_OK;
                    r.fkey = tbl_key[i];
                    r.fval = tbl_val[i];
                    r.slot = i[9:0];
                    break;
                end
            end
        end
        r.count = live_cnt;
        return r;
    endfunction

    function automatic logic [63:0] random_key();
        logic [63:0] k;
        int n, sel;
        k = '0;
        n = $urandom_range(8);
        for (int i = 0; i < 8; i++) begin
            sel = $urandom_range(3);
            if (i < n) begin
                if (sel == 0) k[8*i +: 8] = 8'($urandom_range("Z", "A"));
                else if (sel == 1) k[8*i +: 8] = 8'($urandom_range("z", "a"));
                else k[8*i +: 8] = 8'($urandom_range(255, 1));
            end else if (i > n && sel[0]) begin
                k[8*i +: 8] = 8'($urandom);
            end
        end
        return k;
    endfunction

    task automatic push_cmd(logic [2:0] c, logic [63:0] k, logic [63:0] v);
        pending_cmds.push_back('{cmd: c, key: k, val: v});
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic empty_and_resize(logic [10:0] v);
        wait_idle();
        for (int i = 0; i < cap; i++)
            if (tbl_used[i] && tbl_live[i]) push_cmd(lpht_pkg::CMD_ERASE, tbl_key[i], 64'd0);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        capacity_write(v);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_phase(int n_items, int pool_size);
        logic [63:0] k;
        int pick;
        key_pool.delete();
        for (int i = 0; i < pool_size; i++) key_pool.push_back(random_key());
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(99);
            k = ($urandom_range(9) == 0) ? random_key()
                                          : key_pool[$urandom_range(pool_size - 1)];
            if (pick < 36) push_cmd(lpht_pkg::CMD_INSERT, k, {$urandom, $urandom});
            else if (pick < 56) push_cmd(lpht_pkg::CMD_ERASE, k, {$urandom, $urandom});
            else if (pick < 80) push_cmd(lpht_pkg::CMD_SEARCH, k, {$urandom, $urandom});
            else if (pick < 85) push_cmd(lpht_pkg::CMD_FIRST, k, {$urandom, $urandom});
            else if (pick < 96) push_cmd(lpht_pkg::CMD_NEXT, k, {$urandom, $urandom});
            else push_cmd(3'($urandom_range(7, 5)), k, {$urandom, $urandom});
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // driver: offer the head of the pending queue, predict on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid)
                expected_results.push_back(table_apply(s_axis_tdata[130:0]));
            if (pending_cmds.size() != 0 && (quiet || $urandom_range(99) >= 24)) begin
                s_axis_tdata <= {5'd0, pending_cmds.pop_front()};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: random backpressure, one long hold-off, field checks
    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
            stall_done <= 1'b0;
            results_seen <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[150:0];
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected item %h", $time, got);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                        fails++;
                    end
                    if (got.fkey !== want.fkey) begin
                        $display("%0t: found_key exp %h got %h", $time, want.fkey, got.fkey);
                        fails++;
                    end
                    if (got.fval !== want.fval) begin
                        $display("%0t: found_value exp %h got %h", $time, want.fval, got.fval);
                        fails++;
                    end
                    if (got.slot !== want.slot) begin
                        $display("%0t: slot_index exp %0d got %0d", $time, want.slot, got.slot);
                        fails++;
                    end
                    if (got.count !== want.count) begin
                        $display("%0t: entry_count exp %0d got %0d", $time, want.count,
                                 got.count);
                        fails++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end else if (!stall_done && results_seen >= 300) begin
                stall_left <= 500;
                stall_done <= 1'b1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= quiet || ($urandom_range(99) >= 24);
            end
        end
    end

    initial begin
        #30ms;
        $display("tb: failure");
        $finish;
    end

    initial begin
        quiet = 1'b0;
        live_cnt = '0;
        cap = lpht_pkg::CAP_RESET;
        table_clear();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        push_cmd(lpht_pkg::CMD_NEXT, 64'd0, 64'd0);
        push_cmd(lpht_pkg::CMD_FIRST, 64'd0, 64'd0);
        push_cmd(lpht_pkg::CMD_INSERT, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        push_cmd(lpht_pkg::CMD_INSERT, 64'h0000_0000_0043_4241, 64'd0);
        push_cmd(lpht_pkg::CMD_INSERT, 64'h0000_0000_0063_6261, 64'h1234_5678_9ABC_DEF0);
        push_cmd(lpht_pkg::CMD_INSERT, 64'h5555_5500_0043_4241, 64'd7);
        push_cmd(lpht_pkg::CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 64'hA5A5_A5A5_5A5A_5A5A);
        push_cmd(lpht_pkg::CMD_INSERT, 64'h8081_FEFF_7A5A_4161, 64'h8000_0000_0000_0001);
        push_cmd(lpht_pkg::CMD_SEARCH, 64'h0000_0000_0063_6261, 64'd0);
        push_cmd(lpht_pkg::CMD_SEARCH, 64'h0000_0000_0043_6261, 64'd0);
        push_cmd(lpht_pkg::CMD_SEARCH, 64'hFF00_0000_0000_0000, 64'd0);
        push_cmd(lpht_pkg::CMD_ERASE, 64'h0000_0000_0043_4241, 64'd0);
        push_cmd(lpht_pkg::CMD_ERASE, 64'h0000_0000_0043_4241, 64'd0);
        push_cmd(lpht_pkg::CMD_SEARCH, 64'h0000_0000_0063_6261, 64'd0);
        push_cmd(lpht_pkg::CMD_INSERT, 64'h0000_0000_0043_4241, 64'd99);
        push_cmd(lpht_pkg::CMD_FIRST, 64'd0, 64'd0);
        for (int i = 0; i < 5; i++) push_cmd(lpht_pkg::CMD_NEXT, 64'd0, 64'd0);
        push_cmd(3'd5, 64'd1, 64'd1);
        push_cmd(3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        random_phase(40, 12);

        // capacity sweep, extremes included
        empty_and_resize(11'd0);
        random_phase(80, 4);
        empty_and_resize(11'd2);
        random_phase(120, 6);
        empty_and_resize(11'd7);
        quiet <= 1'b1;
        random_phase(200, 20);
        wait_idle();
        quiet <= 1'b0;
        empty_and_resize(11'd13);
        random_phase(250, 30);
        empty_and_resize(11'd64);
        random_phase(300, 90);
        empty_and_resize(11'd5);
        random_phase(150, 12);
        empty_and_resize(11'd2047);
        random_phase(60, 20);
        empty_and_resize(11'd1000);
        random_phase(80, 20);
        empty_and_resize(11'd1);
        random_phase(60, 3);
        wait_idle();
        if (fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// ===== linear_probe_hash_table.f =====
+incdir+rtl
rtl/lpht_pkg.sv
rtl/lpht_mod.sv
rtl/linear_probe_hash_table.sv
sim/tb_linear_probe_hash_table.sv
